>>> sv/sfc_pkg.sv
// Shared types, codes and constants of the sphere frustum cull block.
// No dependencies; every other file but sfc_if imports this package.
package sfc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_ROWS  = 3;
	localparam int NUM_CFG   = 6;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	// register indexes on the config port
	typedef enum logic [2:0] {
		CFG_NEAR   = 3'd0,
		CFG_FAR    = 3'd1,
		CFG_RIGHT  = 3'd2,
		CFG_LEFT   = 3'd3,
		CFG_TOP    = 3'd4,
		CFG_BOTTOM = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_TEST = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		HIT_NONE  = 3'd0,
		HIT_LEFT  = 3'd1,
		HIT_RIGHT = 3'd2,
		HIT_FAR   = 3'd3,
		HIT_NEAR  = 3'd4
	} hit_t;

	typedef enum logic [3:0] {
		PL_IDLE, PL_FMUL, PL_FDIV, PL_FSTORE,
		PL_EDGE, PL_EFIT, PL_XMUL, PL_XSUB,
		PL_CSHR, PL_CSHL, PL_SQMUL, PL_SQSUM,
		PL_SQRT, PL_NLOAD, PL_NDIV, PL_NSTORE
	} pl_state_t;

	localparam logic signed [31:0] ONE_Q      = 32'(1) << FRAC_BITS;
	localparam logic [30:0]        NEAR_RST   = 31'(1) << FRAC_BITS;
	localparam logic [30:0]        FAR_RST    = 31'(100) << FRAC_BITS;
	localparam logic signed [31:0] POS_RST    = 32'(1) << FRAC_BITS;
	localparam logic signed [31:0] NEG_RST    = -(32'(1) << FRAC_BITS);

	typedef struct packed {
		logic        we;
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	// view-space sphere: centre and radius
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] r;
	} point_t;

	// left, right, far, near planes; x, y, z components
	typedef struct {
		logic signed [31:0] nrm [4][3];
		logic signed [31:0] anc [4][3];
	} planes_t;

endpackage

>>> sv/sfc_if.sv
// Valid/ready channel interfaces for item words and result words.
// No dependencies.
interface sfc_item_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [1:0]         row;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic signed [31:0] z_value;
	logic signed [31:0] w_value;

	modport source (output valid, kind, row, x_value, y_value, z_value, w_value,
		input ready);
	modport sink (input valid, kind, row, x_value, y_value, z_value, w_value,
		output ready);
endinterface

interface sfc_result_if;
	logic       valid;
	logic       ready;
	logic       culled;
	logic [2:0] hit_plane;

	modport source (output valid, culled, hit_plane, input ready);
	modport sink (input valid, culled, hit_plane, output ready);
endinterface

>>> sv/sfc_plane.sv
// Plane derivation sequencer: config registers, far corners, normals, anchors.
// Depends on sfc_pkg. One shared bit-serial divider and a 2-bit/step root.
module sfc_plane (
	input  logic             clk,
	input  logic             arst_n,
	input  sfc_pkg::cfg_wr_t cfg,
	output sfc_pkg::planes_t planes,
	output logic             busy
);
	import sfc_pkg::*;

	localparam int SQRT_TOP = 62;

	pl_state_t state_q, state_n;
	logic [1:0] fidx_q, pk_q, ci_q;
	logic [5:0] cnt_q;

	logic [30:0]        near_q, far_q;
	logic signed [31:0] right_q, left_q, top_q, bottom_q;
	logic signed [31:0] farx_q [4];

	logic [33:0]        emag_q [6];
	logic               eneg_q [6];
	logic signed [61:0] xp_q [6];
	logic [62:0]        cmag_q [3];
	logic               cneg_q [3];
	logic [59:0]        sq_q [3];
	logic [63:0]        sx_q, sres_q, sbit_q;
	logic [63:0]        dq_q;
	logic [31:0]        dr_q, dv_q;
	logic               dneg_q;
	logic signed [31:0] nrm_q [4][3];
	logic signed [31:0] anc_q [4][3];

	// combinational helpers
	logic               div_last, sqrt_last, e_big, c_big, c_grow;
	logic [32:0]        trial;
	logic               ge;
	logic [31:0]        rem_n;
	logic [63:0]        st;
	logic signed [31:0] ext_sel;
	logic signed [63:0] fprod;
	logic [63:0]        fmag;
	logic signed [31:0] fsat;
	logic signed [32:0] cl, cr, ct, cb, clf, crf, ctf, cbf, cn, cf;
	logic signed [32:0] p1 [3], p2 [3], p3 [3];
	logic signed [33:0] ed [6];
	logic signed [30:0] ev [6];
	logic signed [62:0] cv [3];

	// divider and root steps
	always_comb begin
		trial = {dr_q, dq_q[63]};
		ge    = trial >= {1'b0, dv_q};
		rem_n = ge ? 32'(trial - {1'b0, dv_q}) : trial[31:0];
		st    = sres_q + sbit_q;
	end

	// far-corner scaling: product, then saturation of the quotient
	always_comb begin
		case (fidx_q)
			2'd0:    ext_sel = left_q;
			2'd1:    ext_sel = right_q;
			2'd2:    ext_sel = top_q;
			default: ext_sel = bottom_q;
		endcase
		fprod = ext_sel * $signed({1'b0, far_q});
		fmag  = fprod[63] ? 64'(-fprod) : 64'(fprod);
		if (dneg_q)
			fsat = (dq_q > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(dq_q[31:0]);
		else
			fsat = (dq_q > 64'h7fff_ffff) ? 32'sh7fff_ffff : $signed(dq_q[31:0]);
	end

	// corner selection for the plane being built
	always_comb begin
		cl  = 33'(left_q);
		cr  = 33'(right_q);
		ct  = 33'(top_q);
		cb  = 33'(bottom_q);
		clf = 33'(farx_q[0]);
		crf = 33'(farx_q[1]);
		ctf = 33'(farx_q[2]);
		cbf = 33'(farx_q[3]);
		cn  = -$signed({2'b00, near_q});
		cf  = -$signed({2'b00, far_q});
		case (pk_q)
			2'd0: begin
				p1 = '{cl, ct, cn}; p2 = '{clf, ctf, cf}; p3 = '{cl, cb, cn};
			end
			2'd1: begin
				p1 = '{cr, ct, cn}; p2 = '{cr, cb, cn}; p3 = '{crf, ctf, cf};
			end
			2'd2: begin
				p1 = '{clf, ctf, cf}; p2 = '{crf, ctf, cf}; p3 = '{clf, cbf, cf};
			end
			default: begin
				p1 = '{cl, cb, cn}; p2 = '{cr, cb, cn}; p3 = '{cl, ct, cn};
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			ed[i]     = p2[i] - p1[i];
			ed[i + 3] = p3[i] - p1[i];
		end
	end

	always_comb begin
		e_big = 1'b0;
		for (int i = 0; i < 6; i++) begin
			ev[i] = eneg_q[i] ? -$signed({1'b0, emag_q[i][29:0]})
				: $signed({1'b0, emag_q[i][29:0]});
			if (emag_q[i][33:30] != 4'd0)
				e_big = 1'b1;
		end
		cv[0] = 63'(xp_q[0]) - 63'(xp_q[1]);
		cv[1] = 63'(xp_q[2]) - 63'(xp_q[3]);
		cv[2] = 63'(xp_q[4]) - 63'(xp_q[5]);
		c_big  = 1'b0;
		c_grow = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (cmag_q[i][62:30] != 33'd0)
				c_big = 1'b1;
			if (cmag_q[i][29])
				c_grow = 1'b0;
		end
		// an all-zero cross product is left alone
		if (cmag_q[0] == 63'd0 && cmag_q[1] == 63'd0 && cmag_q[2] == 63'd0)
			c_grow = 1'b0;
	end

	// outputs of the sequencer
	always_comb begin
		busy      = state_q != PL_IDLE;
		div_last  = cnt_q == 6'd63;
		sqrt_last = cnt_q == 6'd31;
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			PL_IDLE:   if (cfg.we && cfg.index < 3'(NUM_CFG)) state_n = PL_FMUL;
			PL_FMUL:   state_n = (near_q == 31'd0) ? PL_FSTORE : PL_FDIV;
			PL_FDIV:   if (div_last) state_n = PL_FSTORE;
			PL_FSTORE: state_n = (fidx_q == 2'd3) ? PL_EDGE : PL_FMUL;
			PL_EDGE:   state_n = PL_EFIT;
			PL_EFIT:   if (!e_big) state_n = PL_XMUL;
			PL_XMUL:   state_n = PL_XSUB;
			PL_XSUB:   state_n = PL_CSHR;
			PL_CSHR:   if (!c_big) state_n = PL_CSHL;
			PL_CSHL:   if (!c_grow) state_n = PL_SQMUL;
			PL_SQMUL:  state_n = PL_SQSUM;
			PL_SQSUM:  state_n = PL_SQRT;
			PL_SQRT:   if (sqrt_last) state_n = PL_NLOAD;
			PL_NLOAD:  state_n = (sres_q == 64'd0) ? PL_NSTORE : PL_NDIV;
			PL_NDIV:   if (div_last) state_n = PL_NSTORE;
			PL_NSTORE: begin
				if (ci_q == 2'd2)
					state_n = (pk_q == 2'd3) ? PL_IDLE : PL_EDGE;
				else
					state_n = PL_NLOAD;
			end
			default:   state_n = PL_IDLE;
		endcase
		// a write mid-derivation restarts from the first far corner
		if (cfg.we && cfg.index < 3'(NUM_CFG))
			state_n = PL_FMUL;
	end

	// control and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= PL_FMUL;
			fidx_q   <= 2'd0;
			pk_q     <= 2'd0;
			ci_q     <= 2'd0;
			cnt_q    <= 6'd0;
			near_q   <= NEAR_RST;
			far_q    <= FAR_RST;
			right_q  <= POS_RST;
			left_q   <= NEG_RST;
			top_q    <= POS_RST;
			bottom_q <= NEG_RST;
		end else begin
			state_q <= state_n;
			if (cfg.we) begin
				case (cfg.index)
					CFG_NEAR:   near_q   <= cfg.data[30:0];
					CFG_FAR:    far_q    <= cfg.data[30:0];
					CFG_RIGHT:  right_q  <= $signed(cfg.data);
					CFG_LEFT:   left_q   <= $signed(cfg.data);
					CFG_TOP:    top_q    <= $signed(cfg.data);
					CFG_BOTTOM: bottom_q <= $signed(cfg.data);
					default: ;
				endcase
			end
			case (state_q)
				PL_IDLE:   fidx_q <= 2'd0;
				PL_FMUL:   cnt_q  <= 6'd0;
				PL_FDIV:   cnt_q  <= cnt_q + 6'd1;
				PL_FSTORE: begin
					fidx_q <= fidx_q + 2'd1;
					pk_q   <= 2'd0;
				end
				PL_SQSUM:  cnt_q <= 6'd0;
				PL_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					ci_q  <= 2'd0;
				end
				PL_NLOAD:  cnt_q <= 6'd0;
				PL_NDIV:   cnt_q <= cnt_q + 6'd1;
				PL_NSTORE: begin
					if (ci_q == 2'd2) begin
						ci_q <= 2'd0;
						pk_q <= pk_q + 2'd1;
					end else begin
						ci_q <= ci_q + 2'd1;
					end
				end
				default: ;
			endcase
			if (cfg.we && cfg.index < 3'(NUM_CFG))
				fidx_q <= 2'd0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			PL_FMUL: begin
				dr_q   <= 32'd0;
				dv_q   <= {1'b0, near_q};
				dneg_q <= ext_sel < 0;
				if (near_q == 31'd0)
					dq_q <= (ext_sel == 0) ? 64'd0 : '1;
				else
					dq_q <= fmag;
			end
			PL_FDIV, PL_NDIV: begin
				dq_q <= {dq_q[62:0], ge};
				dr_q <= rem_n;
			end
			PL_FSTORE: farx_q[fidx_q] <= fsat;
			PL_EDGE: begin
				for (int i = 0; i < 6; i++) begin
					eneg_q[i] <= ed[i][33];
					emag_q[i] <= ed[i][33] ? 34'(-ed[i]) : 34'(ed[i]);
				end
				for (int i = 0; i < 3; i++)
					anc_q[pk_q][i] <= p1[i][31:0];
			end
			PL_EFIT: begin
				if (e_big)
					for (int i = 0; i < 6; i++)
						emag_q[i] <= emag_q[i] >> 1;
			end
			PL_XMUL: begin
				xp_q[0] <= ev[1] * ev[5];
				xp_q[1] <= ev[2] * ev[4];
				xp_q[2] <= ev[2] * ev[3];
				xp_q[3] <= ev[0] * ev[5];
				xp_q[4] <= ev[0] * ev[4];
				xp_q[5] <= ev[1] * ev[3];
			end
			PL_XSUB: begin
				for (int i = 0; i < 3; i++) begin
					cneg_q[i] <= cv[i][62];
					cmag_q[i] <= cv[i][62] ? 63'(-cv[i]) : 63'(cv[i]);
				end
			end
			PL_CSHR: begin
				if (c_big)
					for (int i = 0; i < 3; i++)
						cmag_q[i] <= cmag_q[i] >> 1;
			end
			PL_CSHL: begin
				if (c_grow)
					for (int i = 0; i < 3; i++)
						cmag_q[i] <= cmag_q[i] << 1;
			end
			PL_SQMUL: begin
				for (int i = 0; i < 3; i++)
					sq_q[i] <= cmag_q[i][29:0] * cmag_q[i][29:0];
			end
			PL_SQSUM: begin
				sx_q   <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
				sres_q <= 64'd0;
				sbit_q <= 64'(1) << SQRT_TOP;
			end
			PL_SQRT: begin
				if (sx_q >= st) begin
					sx_q   <= sx_q - st;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			PL_NLOAD: begin
				dr_q   <= 32'd0;
				dv_q   <= sres_q[31:0];
				dneg_q <= cneg_q[ci_q];
				dq_q   <= (sres_q == 64'd0) ? 64'd0 : 64'(cmag_q[ci_q]) << FRAC_BITS;
			end
			PL_NSTORE:
				nrm_q[pk_q][ci_q] <= dneg_q ? -$signed(dq_q[31:0]) : $signed(dq_q[31:0]);
			default: ;
		endcase
	end

	always_comb begin
		planes.nrm = nrm_q;
		planes.anc = anc_q;
	end

endmodule

>>> sv/sfc_front.sv
// Front end: takes item words, keeps the view matrix, transforms centres.
// Depends on sfc_pkg and sfc_item_if.
module sfc_front (
	input  logic            clk,
	input  logic            arst_n,
	sfc_item_if.sink        items,
	input  logic            hold,
	output sfc_pkg::point_t pt,
	output logic            pt_valid,
	input  logic            pt_ready
);
	import sfc_pkg::*;

	logic signed [31:0] mat_q [3][4];
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] tr_s1 [3];
	logic signed [31:0] rad_s1;
	logic               v_s1, v_s2;
	point_t             pt_s2;

	logic               adv, take, is_test;
	logic signed [31:0] vin [3];
	logic signed [65:0] acc [3];
	logic signed [31:0] sat [3];

	assign adv         = !v_s2 || pt_ready;
	assign items.ready = adv && !hold;
	assign take        = items.valid && items.ready;
	assign is_test     = items.kind == KIND_TEST;

	always_comb begin
		vin = '{items.x_value, items.y_value, items.z_value};
		for (int i = 0; i < 3; i++) begin
			acc[i] = 66'(tr_s1[i]) + 66'(prod_s1[i][0] >>> FRAC_BITS)
				+ 66'(prod_s1[i][1] >>> FRAC_BITS) + 66'(prod_s1[i][2] >>> FRAC_BITS);
			if (acc[i][65:31] == {35{acc[i][31]}})
				sat[i] = acc[i][31:0];
			else
				sat[i] = acc[i][65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 4; j++)
					mat_q[i][j] <= (i == j) ? ONE_Q : 32'sd0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take && !is_test && items.row < 2'(NUM_ROWS)) begin
				mat_q[items.row][0] <= items.x_value;
				mat_q[items.row][1] <= items.y_value;
				mat_q[items.row][2] <= items.z_value;
				mat_q[items.row][3] <= items.w_value;
			end
			if (adv) begin
				v_s1 <= take && is_test;
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					prod_s1[i][j] <= mat_q[i][j] * vin[j];
				tr_s1[i] <= mat_q[i][3];
			end
			rad_s1  <= items.w_value;
			pt_s2.x <= sat[0];
			pt_s2.y <= sat[1];
			pt_s2.z <= sat[2];
			pt_s2.r <= rad_s1;
		end
	end

	assign pt       = pt_s2;
	assign pt_valid = v_s2;

endmodule

>>> sv/sfc_fifo.sv
// Short queue of view-space spheres between front and back.
// Depends on sfc_pkg.
module sfc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sfc_pkg::point_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sfc_pkg::point_t pop_data
);
	import sfc_pkg::*;

	point_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   count_q;
	logic              push, pop;

	assign push_ready = count_q != (QPTR_W + 1)'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_data;
	end

endmodule

>>> sv/sfc_back.sv
// Back end: signed distance of each sphere to four planes, first hit wins.
// Depends on sfc_pkg and sfc_result_if.
module sfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sfc_pkg::planes_t planes,
	input  logic             pt_valid,
	output logic             pt_ready,
	input  sfc_pkg::point_t  pt,
	sfc_result_if.source     results
);
	import sfc_pkg::*;

	logic signed [64:0] prod_s1 [4][3];
	logic signed [31:0] rad_s1;
	logic               v_s1, v_s2;
	logic               culled_s2;
	hit_t               hit_s2;

	logic               en;
	logic signed [31:0] pc [3];
	logic signed [32:0] df [4][3];
	logic signed [66:0] dsum [4];
	logic               hit [4];
	hit_t               hit_n;

	assign en       = !v_s2 || results.ready;
	assign pt_ready = en;

	always_comb begin
		pc = '{pt.x, pt.y, pt.z};
		for (int k = 0; k < 4; k++)
			for (int i = 0; i < 3; i++)
				df[k][i] = 33'(pc[i]) - 33'(planes.anc[k][i]);
		for (int k = 0; k < 4; k++) begin
			dsum[k] = 67'(prod_s1[k][0]) + 67'(prod_s1[k][1]) + 67'(prod_s1[k][2]);
			hit[k]  = (dsum[k] >>> FRAC_BITS) > 67'(rad_s1);
		end
		if (hit[0])
			hit_n = HIT_LEFT;
		else if (hit[1])
			hit_n = HIT_RIGHT;
		else if (hit[2])
			hit_n = HIT_FAR;
		else if (hit[3])
			hit_n = HIT_NEAR;
		else
			hit_n = HIT_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= pt_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++)
				for (int i = 0; i < 3; i++)
					prod_s1[k][i] <= df[k][i] * planes.nrm[k][i];
			rad_s1    <= pt.r;
			culled_s2 <= hit_n != HIT_NONE;
			hit_s2    <= hit_n;
		end
	end

	assign results.valid     = v_s2;
	assign results.culled    = culled_s2;
	assign results.hit_plane = hit_s2;

endmodule

>>> sv/sphere_frustum_cull.sv
// Top level of the sphere frustum cull block: plane sequencer, front, queue, back.
// Depends on sfc_pkg, sfc_if, sfc_plane, sfc_front, sfc_fifo and sfc_back.
//
// channel   dir  handshake        word
// items     in   valid/ready      kind, row, x_value, y_value, z_value, w_value
// results   out  valid/ready      culled, hit_plane
// cfg       in   cfg_we strobe    cfg_index, cfg_data
//
// Sphere tests: one word per cycle sustained unless plane derivation or
// result back-pressure stalls it; two front stages (multiply, sum and
// saturate), the queue, then two back stages (plane products, distance sums
// and compare). Load words update the matrix at acceptance. Plane derivation
// runs after reset and after every config write to a valid index; items are
// held off while it runs, its length set by the shared bit-serial divider
// (16 quotients) and the 32-step square root. A write during derivation restarts it.
// Front and back stall on their own; the queue absorbs up to 4 spheres.
module sphere_frustum_cull (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	sfc_item_if.sink     items,
	sfc_result_if.source results
);
	import sfc_pkg::*;

	cfg_wr_t cfg;
	planes_t planes;
	logic    pl_busy;

	// front to queue, queue to back
	point_t  f_pt, b_pt;
	logic    f_valid, f_ready, b_valid, b_ready;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	sfc_plane u_plane (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.planes (planes),
		.busy   (pl_busy)
	);

	// front holds off while planes are being rebuilt
	sfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.hold     (pl_busy),
		.pt       (f_pt),
		.pt_valid (f_valid),
		.pt_ready (f_ready)
	);

	sfc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_pt),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_pt)
	);

	sfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.planes   (planes),
		.pt_valid (b_valid),
		.pt_ready (b_ready),
		.pt       (b_pt),
		.results  (results)
	);

`ifndef SYNTH
	a_busy_holds_items: assert property (@(posedge clk) disable iff (!arst_n)
		pl_busy |-> !items.ready)
		else $error("item word accepted during plane derivation");

	a_cull_matches_plane: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.culled == (results.hit_plane != HIT_NONE)))
		else $error("culled flag disagrees with hit plane");

	a_cfg_rederives: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index < 3'(NUM_CFG) && !pl_busy) |=> pl_busy)
		else $error("config write did not start plane derivation");
`endif

endmodule
